/* rtl/lcp_pkg.sv */
// ----------------------------------------------------------------------------
// Logical channel prioritization package
// Shared widths, register indexes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lcp_pkg;

   // Channel slots carried by the request, the result and the tables.
   localparam int SLOTS                = 4;
   localparam int DEFAULT_NUM_CHANNELS = 4;
   localparam int FIELD_W              = 16;
   localparam int SLOT_IDX_W           = $clog2(SLOTS);
   // Remaining space can dip a few bytes below zero in the second round.
   localparam int SPACE_W              = FIELD_W + 2;
   localparam int HDR_W                = 2;

   localparam int CSR_IDX_W            = 2;
   localparam int CSR_DATA_W           = SLOTS * FIELD_W;

   localparam logic [FIELD_W-1:0] RATE_INFINITE = 16'hFFFF;
   localparam logic [FIELD_W-1:0] SHORT_SDU_MAX = 16'd127;
   localparam logic [HDR_W-1:0]   HDR_SHORT     = 2'd2;
   localparam logic [HDR_W-1:0]   HDR_LONG      = 2'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE   = 2'd0,
      CSR_BUCKET = 2'd1,
      CSR_CCCH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  load;
      logic                  tick_step;
      logic                  r1_step;
      logic                  r2_step;
      logic                  out_load;
      logic                  last;
      logic [SLOT_IDX_W-1:0] slot;
   } lcp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } lcp_status_type;

endpackage

/* rtl/lcp_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one tick or one uplink grant.
// ----------------------------------------------------------------------------
interface lcp_req_if;
   import lcp_pkg::*;

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [FIELD_W-1:0] grant_space;
   logic [FIELD_W-1:0] pending_bytes_0;
   logic [FIELD_W-1:0] pending_bytes_1;
   logic [FIELD_W-1:0] pending_bytes_2;
   logic [FIELD_W-1:0] pending_bytes_3;

   modport source (
      output valid, req_type, grant_space,
      output pending_bytes_0, pending_bytes_1, pending_bytes_2, pending_bytes_3,
      input  ready
   );

   modport sink (
      input  valid, req_type, grant_space,
      input  pending_bytes_0, pending_bytes_1, pending_bytes_2, pending_bytes_3,
      output ready
   );

endinterface

/* rtl/lcp_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the per-slot grant split of one uplink grant.
// ----------------------------------------------------------------------------
interface lcp_rsp_if;
   import lcp_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] granted_bytes_0;
   logic [FIELD_W-1:0] granted_bytes_1;
   logic [FIELD_W-1:0] granted_bytes_2;
   logic [FIELD_W-1:0] granted_bytes_3;
   logic [FIELD_W-1:0] space_left;

   modport source (
      output valid,
      output granted_bytes_0, granted_bytes_1, granted_bytes_2, granted_bytes_3,
      output space_left,
      input  ready
   );

   modport sink (
      input  valid,
      input  granted_bytes_0, granted_bytes_1, granted_bytes_2, granted_bytes_3,
      input  space_left,
      output ready
   );

endinterface

/* rtl/lcp_ctrl.sv */
// ----------------------------------------------------------------------------
// Logical channel prioritization controller
// Sequences the credit walk for a tick and the two slot walks for a grant.
// ----------------------------------------------------------------------------
module lcp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_grant,
   output logic                    req_ready,
   input  lcp_pkg::lcp_status_type status,
   output lcp_pkg::lcp_cmd_type    cmd
);
   import lcp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_TICK   = 5'b00010,
      S_ROUND1 = 5'b00100,
      S_ROUND2 = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   localparam logic [SLOT_IDX_W-1:0] LastSlot = SLOT_IDX_W'(SLOTS - 1);

   state_type             state_ff, state_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   logic                  last;

   assign last = (slot_ff == LastSlot);

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.slot      = slot_ff;
      cmd.last      = last;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            slot_in   = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_is_grant ? S_ROUND1 : S_TICK;
            end
         end
         S_TICK: begin
            cmd.tick_step = 1'b1;
            slot_in       = last ? '0 : slot_ff + 1'b1;
            if (last) begin
               state_in = S_IDLE;
            end
         end
         S_ROUND1: begin
            cmd.r1_step = 1'b1;
            slot_in     = last ? '0 : slot_ff + 1'b1;
            if (last) begin
               state_in = S_ROUND2;
            end
         end
         S_ROUND2: begin
            cmd.r2_step = 1'b1;
            slot_in     = last ? '0 : slot_ff + 1'b1;
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            slot_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

/* rtl/lcp_dp.sv */
// ----------------------------------------------------------------------------
// Logical channel prioritization datapath
// Holds the tables, the channel credits, the working grant state and the
// result register; performs one slot step per command.
// ----------------------------------------------------------------------------
module lcp_dp #(
   parameter int NUM_CHANNELS = lcp_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [lcp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lcp_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic [lcp_pkg::FIELD_W-1:0]             grant_space,
   input  logic [lcp_pkg::SLOTS-1:0][lcp_pkg::FIELD_W-1:0] pend_in,
   input  lcp_pkg::lcp_cmd_type                    cmd,
   output lcp_pkg::lcp_status_type                 status,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [lcp_pkg::SLOTS-1:0][lcp_pkg::FIELD_W-1:0] granted,
   output logic [lcp_pkg::FIELD_W-1:0]             space_left
);
   import lcp_pkg::*;

   logic [SLOTS-1:0]               active;
   logic [SLOTS-1:0][FIELD_W-1:0]  rate_ff;
   logic [SLOTS-1:0][FIELD_W-1:0]  bucket_ff;
   logic [SLOTS-1:0]               ccch_ff;
   logic [SLOTS-1:0][FIELD_W-1:0]  credit_ff;
   logic [SLOTS-1:0][FIELD_W-1:0]  pend_ff;
   logic [SLOTS-1:0][FIELD_W-1:0]  got_ff;
   logic signed [SPACE_W-1:0]      space_ff;
   logic [HDR_W-1:0]               last_hdr_ff;
   logic                           rsp_valid_ff;
   logic [SLOTS-1:0][FIELD_W-1:0]  granted_ff;
   logic [FIELD_W-1:0]             space_left_ff;

   logic [FIELD_W-1:0]        pend_cur, cred_cur, rate_cur, bucket_cur, got_cur;
   logic                      inf, space_pos;
   logic [FIELD_W-1:0]        space16;
   logic                      r1_ok;
   logic [FIELD_W-1:0]        r1_lim, r1_amt, r1_rem;
   logic [HDR_W-1:0]          r1_hdr, r1_hdr_cap;
   logic signed [SPACE_W-1:0] space_refund;
   logic signed [SPACE_W-1:0] r2_space;
   logic                      r2_ok;
   logic [FIELD_W-1:0]        r2_amt;
   logic [FIELD_W:0]          tick_sum;
   logic [FIELD_W-1:0]        tick_credit;

   for (genvar g = 0; g < SLOTS; g++) begin : g_active
      assign active[g] = (g < NUM_CHANNELS);
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= '0;
         bucket_ff <= '0;
         ccch_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:   rate_ff   <= csr_wdata;
            CSR_BUCKET: bucket_ff <= csr_wdata;
            CSR_CCCH:   ccch_ff   <= csr_wdata[SLOTS-1:0];
            default:    ;
         endcase
      end
   end

   // Per-slot operands selected by the controller's slot index.
   always_comb begin
      pend_cur   = pend_ff[cmd.slot];
      cred_cur   = credit_ff[cmd.slot];
      rate_cur   = rate_ff[cmd.slot];
      bucket_cur = bucket_ff[cmd.slot];
      got_cur    = got_ff[cmd.slot];
      inf        = (rate_cur == RATE_INFINITE);
      space_pos  = !space_ff[SPACE_W-1] && (space_ff != '0);
      space16    = space_ff[FIELD_W-1:0];

      // First round: limited by credit, then a subheader charge.
      r1_ok      = (inf || cred_cur != '0) && space_pos && (pend_cur != '0);
      r1_lim     = (!inf && cred_cur < pend_cur) ? cred_cur : pend_cur;
      r1_amt     = (r1_lim > space16) ? space16 : r1_lim;
      r1_rem     = space16 - r1_amt;
      r1_hdr     = (r1_amt <= SHORT_SDU_MAX) ? HDR_SHORT : HDR_LONG;
      r1_hdr_cap = (FIELD_W'(r1_hdr) > r1_rem) ? r1_rem[HDR_W-1:0] : r1_hdr;
      space_refund = space_ff + $signed(SPACE_W'(last_hdr_ff));

      // Second round: no credit limit.
      r2_space = (got_cur == '0 && pend_cur != '0)
                 ? space_ff - $signed(SPACE_W'(last_hdr_ff)) : space_ff;
      r2_ok    = !ccch_ff[cmd.slot] && (pend_cur != '0)
                 && !r2_space[SPACE_W-1] && (r2_space != '0);
      r2_amt   = (pend_cur > r2_space[FIELD_W-1:0]) ? r2_space[FIELD_W-1:0] : pend_cur;

      // Tick: add the rate unless infinite, clamp at the bucket size.
      tick_sum    = {1'b0, cred_cur} + (inf ? '0 : {1'b0, rate_cur});
      tick_credit = (tick_sum > {1'b0, bucket_cur}) ? bucket_cur : tick_sum[FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else if (cmd.tick_step && active[cmd.slot]) begin
         credit_ff[cmd.slot] <= tick_credit;
      end else if (cmd.r1_step && r1_ok && !inf) begin
         credit_ff[cmd.slot] <= cred_cur - r1_amt;
      end
   end

   // Working grant state.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < SLOTS; i++) begin
            pend_ff[i] <= active[i] ? pend_in[i] : '0;
         end
         got_ff      <= '0;
         space_ff    <= $signed(SPACE_W'(grant_space));
         last_hdr_ff <= '0;
      end else if (cmd.r1_step) begin
         if (r1_ok) begin
            pend_ff[cmd.slot] <= pend_cur - r1_amt;
            got_ff[cmd.slot]  <= r1_amt;
            last_hdr_ff       <= r1_hdr_cap;
            // On the last slot the final charge is refunded straight away.
            space_ff <= cmd.last ? $signed(SPACE_W'(r1_rem))
                                 : $signed(SPACE_W'(r1_rem - FIELD_W'(r1_hdr_cap)));
         end else if (cmd.last) begin
            space_ff <= space_refund;
         end
      end else if (cmd.r2_step && !ccch_ff[cmd.slot]) begin
         if (r2_ok) begin
            got_ff[cmd.slot] <= got_cur + r2_amt;
            space_ff         <= r2_space - $signed(SPACE_W'(r2_amt));
         end else begin
            space_ff <= r2_space;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         granted_ff    <= got_ff;
         space_left_ff <= space_pos ? space16 : '0;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign granted         = granted_ff;
   assign space_left      = space_left_ff;

endmodule

/* rtl/logical_channel_prioritization.sv */
// ----------------------------------------------------------------------------
// Logical channel prioritization
// Token-bucket split of an uplink grant over priority-ordered channel slots.
// ----------------------------------------------------------------------------
// The request channel carries either a tick (req_type low) or an uplink grant
// (req_type high) with the grant space and the bytes pending in each slot.
// A tick adds each slot's prioritized rate to its credit, clamped at the
// bucket size, and produces no response. A grant produces exactly one
// response transfer with the bytes granted per slot and the space left over.
// The user writes the tables through the csr_ port only while the block is
// idle; the block itself does not enforce this. A tick occupies the block
// for the request transfer and a credit walk over every slot. A grant passes
// from its request transfer through the two slot rounds, one slot step per
// cycle through the single datapath, and the result register load before
// the response is offered. No new request is taken before that is through.
// The result register decouples the channels: a new request is accepted
// while an earlier response waits; if the receiver stalls, a second grant
// completes its rounds and then waits until the result register drains.
// Synchronous reset clears the credits, the tables and the response valid.
// ----------------------------------------------------------------------------
module logical_channel_prioritization #(
   parameter int NUM_CHANNELS = lcp_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                           clock,
   input  logic                           reset,
   lcp_req_if.sink                        req_ch,
   lcp_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [lcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcp_pkg::*;

   lcp_cmd_type                   cmd;
   lcp_status_type                status;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [SLOTS-1:0][FIELD_W-1:0] pend_in;
   logic [SLOTS-1:0][FIELD_W-1:0] granted;
   logic [FIELD_W-1:0]            space_left;

   // Gather the pending byte counts into slot order.
   assign pend_in[0] = req_ch.pending_bytes_0;
   assign pend_in[1] = req_ch.pending_bytes_1;
   assign pend_in[2] = req_ch.pending_bytes_2;
   assign pend_in[3] = req_ch.pending_bytes_3;

   lcp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_is_grant (req_ch.req_type),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   lcp_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .grant_space (req_ch.grant_space),
      .pend_in     (pend_in),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .granted     (granted),
      .space_left  (space_left)
   );

   assign req_ch.ready           = req_ready;
   assign rsp_ch.valid           = rsp_valid;
   assign rsp_ch.granted_bytes_0 = granted[0];
   assign rsp_ch.granted_bytes_1 = granted[1];
   assign rsp_ch.granted_bytes_2 = granted[2];
   assign rsp_ch.granted_bytes_3 = granted[3];
   assign rsp_ch.space_left      = space_left;

   // The controller issues at most one datapath operation per cycle.
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.tick_step, cmd.r1_step, cmd.r2_step, cmd.out_load}))
      else $error("more than one datapath command in a cycle");

   // A request is never taken while a slot walk is in progress.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !(cmd.tick_step || cmd.r1_step || cmd.r2_step))
      else $error("request accepted during a slot walk");

   // A waiting response is never overwritten by a new result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !cmd.out_load)
      else $error("result register loaded while a response was stalled");

   // A response only appears after the second round has been completed.
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.out_load))
      else $error("response raised without a result load");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Logical channel prioritization testbench
// Drives ticks and uplink grants into the block through the request channel,
// predicts the per-slot split of every grant with a token-bucket model kept
// alongside the block, and checks each response transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcp_pkg::*;

   // The block is built with its default number of active slots.
   localparam int ACTIVE_SLOTS = DEFAULT_NUM_CHANNELS;
   // Index past the end of the register list; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // A tick keeps the block busy for its credit walk with no response, so this is
   // comfortably enough for it to fall idle once the last grant has returned.
   localparam int DRAIN_CYCLES = 16;
   // Long enough for a second grant to finish its rounds and block the input.
   localparam int HOLD_CYCLES  = 200;
   localparam int LIMIT_CYCLES = 500000;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_GRANT = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type                      kind;
      logic [FIELD_W-1:0]                space;
      logic [SLOTS-1:0][FIELD_W-1:0]     pending;
   } uplink_req_type;

   typedef struct packed {
      logic [SLOTS-1:0][FIELD_W-1:0]     granted;
      logic [FIELD_W-1:0]                left;
   } grant_split_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lcp_req_if req_if ();
   lcp_rsp_if rsp_if ();

   logic [CSR_DATA_W-1:0] rate_tbl;
   logic [CSR_DATA_W-1:0] bucket_tbl;
   logic [SLOTS-1:0]      ccch_slots;
   logic [FIELD_W-1:0]    credit [SLOTS];

   grant_split_type split_q [$];

   int  failures    = 0;
   int  cycle_count = 0;
   bit  idle_on     = 1'b1;   // sender may insert gaps between transfers
   bit  stall_on    = 1'b1;   // receiver may drop ready in short bursts
   bit  hold_req    = 1'b0;   // receiver holds ready low for a long stretch

   logical_channel_prioritization #(
      .NUM_CHANNELS (ACTIVE_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if.sink),
      .rsp_ch    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Applies one accepted request to the credit state. A tick refills the
   // buckets; a grant runs both rounds and queues the split it should produce.
   function automatic void apply_request(input uplink_req_type r);
      int            i;
      int            space;
      int            amt;
      int            hdr;
      int            pend [SLOTS];
      int            got  [SLOTS];
      bit            inf;
      logic [16:0]   sum;
      logic [FIELD_W-1:0] rate;
      logic [FIELD_W-1:0] bucket;
      grant_split_type res;

      if (r.kind == REQ_TICK) begin
         for (i = 0; i < ACTIVE_SLOTS; i++) begin
            rate   = rate_tbl[i*FIELD_W +: FIELD_W];
            bucket = bucket_tbl[i*FIELD_W +: FIELD_W];
            sum    = {1'b0, credit[i]};
            // An infinite rate adds nothing, but the clamp still applies.
            if (rate != RATE_INFINITE)
               sum = sum + rate;
            if (sum > {1'b0, bucket})
               sum = {1'b0, bucket};
            credit[i] = sum[FIELD_W-1:0];
         end
         return;
      end

      space = int'(r.space);
      for (i = 0; i < SLOTS; i++) begin
         pend[i] = (i < ACTIVE_SLOTS) ? int'(r.pending[i]) : 0;
         got[i]  = 0;
      end

      // Round one: each slot is bounded by its credit unless its rate is
      // infinite. Every slot served is charged a subheader, capped at the
      // space remaining; the last of these charges is given back afterwards.
      hdr = 0;
      for (i = 0; i < ACTIVE_SLOTS; i++) begin
         inf = (rate_tbl[i*FIELD_W +: FIELD_W] == RATE_INFINITE);
         if (!inf && credit[i] == '0)
            continue;
         if (space <= 0 || pend[i] <= 0)
            continue;
         amt = pend[i];
         if (!inf && amt > int'(credit[i]))
            amt = int'(credit[i]);
         if (amt > space)
            amt = space;
         space   -= amt;
         pend[i] -= amt;
         got[i]  += amt;
         if (!inf)
            credit[i] = credit[i] - amt[FIELD_W-1:0];
         hdr = (amt < 128) ? 2 : 3;
         if (hdr > space)
            hdr = space;
         space -= hdr;
      end
      if (hdr > 0)
         space += hdr;

      // Round two: no credit bound, common control slots left out. A slot
      // that is new to this grant pays the last subheader charge, even when
      // that takes the space below zero.
      for (i = 0; i < ACTIVE_SLOTS; i++) begin
         if (ccch_slots[i])
            continue;
         if (got[i] == 0 && pend[i] > 0)
            space -= hdr;
         if (space <= 0 || pend[i] <= 0)
            continue;
         amt = pend[i];
         if (amt > space)
            amt = space;
         space   -= amt;
         pend[i] -= amt;
         got[i]  += amt;
      end

      for (i = 0; i < SLOTS; i++)
         res.granted[i] = got[i][FIELD_W-1:0];
      res.left = (space > 0) ? space[FIELD_W-1:0] : '0;
      split_q = {split_q, res};
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                       input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Every response transfer is matched against the oldest predicted split.
   always @(posedge clock) begin : check_rsp
      grant_split_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (split_q.size() == 0) begin
            $error("response transfer with no grant outstanding");
            failures++;
         end else begin
            want = split_q.pop_front();
            check_field("granted_bytes_0", want.granted[0], rsp_if.granted_bytes_0);
            check_field("granted_bytes_1", want.granted[1], rsp_if.granted_bytes_1);
            check_field("granted_bytes_2", want.granted[2], rsp_if.granted_bytes_2);
            check_field("granted_bytes_3", want.granted[3], rsp_if.granted_bytes_3);
            check_field("space_left", want.left, rsp_if.space_left);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: short random stalls, plus one long hold-off when asked for.
   // -------------------------------------------------------------------------
   initial begin : drive_ready
      int stall_left;
      int n;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(negedge clock);
            hold_req = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender and configuration helpers
   // -------------------------------------------------------------------------

   // Offers one request and returns once it has been transferred. Valid is
   // left high so that back-to-back requests follow without a gap.
   task automatic send_req(input uplink_req_type r);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.req_type        <= r.kind;
      req_if.grant_space     <= r.space;
      req_if.pending_bytes_0 <= r.pending[0];
      req_if.pending_bytes_1 <= r.pending[1];
      req_if.pending_bytes_2 <= r.pending[2];
      req_if.pending_bytes_3 <= r.pending[3];
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      apply_request(r);
   endtask

   // Stops offering requests and waits until the block has gone idle.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (split_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RATE:   rate_tbl   = data;
         CSR_BUCKET: bucket_tbl = data;
         CSR_CCCH:   ccch_slots = data[SLOTS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic uplink_req_type make_req(input req_kind_type kind, input int space,
                                               input int p0, input int p1,
                                               input int p2, input int p3);
      uplink_req_type r;
      r.kind       = kind;
      r.space      = space[FIELD_W-1:0];
      r.pending[0] = p0[FIELD_W-1:0];
      r.pending[1] = p1[FIELD_W-1:0];
      r.pending[2] = p2[FIELD_W-1:0];
      r.pending[3] = p3[FIELD_W-1:0];
      return r;
   endfunction

   // Byte counts spread over empty, tiny, around the subheader boundary,
   // moderate, anything and saturated.
   function automatic logic [FIELD_W-1:0] rand_bytes();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return FIELD_W'($urandom_range(1, 20));
         2:       return FIELD_W'($urandom_range(100, 160));
         3, 4:    return FIELD_W'($urandom_range(0, 3000));
         5:       return FIELD_W'($urandom_range(0, 65535));
         default: return '1;
      endcase
   endfunction

   function automatic uplink_req_type rand_req();
      uplink_req_type r;
      int i;
      r.kind  = ($urandom_range(0, 99) < 35) ? REQ_TICK : REQ_GRANT;
      r.space = rand_bytes();
      for (i = 0; i < SLOTS; i++)
         r.pending[i] = rand_bytes();
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_rates();
      logic [CSR_DATA_W-1:0] t;
      int i;
      for (i = 0; i < SLOTS; i++) begin
         case ($urandom_range(0, 5))
            0:       t[i*FIELD_W +: FIELD_W] = RATE_INFINITE;
            1:       t[i*FIELD_W +: FIELD_W] = '0;
            2, 3:    t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(1, 400));
            4:       t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(1000, 5000));
            default: t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 65535));
         endcase
      end
      return t;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_buckets();
      logic [CSR_DATA_W-1:0] t;
      int i;
      for (i = 0; i < SLOTS; i++) begin
         case ($urandom_range(0, 4))
            0:       t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 100));
            1, 2:    t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(100, 3000));
            3:       t[i*FIELD_W +: FIELD_W] = '1;
            default: t[i*FIELD_W +: FIELD_W] = FIELD_W'($urandom_range(0, 65535));
         endcase
      end
      return t;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-picked requests. Slot 0 is finite and a common control channel,
   // slot 1 infinite with a small bucket, slot 2 finite, slot 3 has a zero
   // rate so its credit never grows.
   task automatic test_directed();
      write_csr(CSR_RATE,   {16'd0, 16'd300, RATE_INFINITE, 16'd100});
      write_csr(CSR_BUCKET, {16'd500, 16'd1000, 16'd50, 16'd200});
      write_csr(CSR_CCCH,   CSR_DATA_W'(4'b0001));
      // No credit anywhere yet: only the infinite slot is served in round one.
      send_req(make_req(REQ_GRANT, 1000, 50, 60, 70, 80));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      // Everything at its maximum.
      send_req(make_req(REQ_GRANT, 65535, 65535, 65535, 65535, 65535));
      // No space, then a single byte of space.
      send_req(make_req(REQ_GRANT, 0, 100, 100, 100, 100));
      send_req(make_req(REQ_GRANT, 1, 1, 1, 1, 1));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      // Either side of the short subheader limit.
      send_req(make_req(REQ_GRANT, 400, 127, 128, 0, 0));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      // Tight space, so the round-two subheader pushes the space negative.
      send_req(make_req(REQ_GRANT, 5, 0, 3, 10, 10));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_GRANT, 131, 90, 0, 40, 7));
      send_req(make_req(REQ_GRANT, 65535, 0, 0, 0, 0));
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      send_req(make_req(REQ_GRANT, 2, 0, 0, 5, 5));
      settle();
   endtask

   // Tables at their extremes, and a write to an index that does not exist.
   task automatic test_table_extremes();
      int n;
      write_csr(CSR_RATE,   '1);
      write_csr(CSR_BUCKET, '1);
      write_csr(CSR_CCCH,   CSR_DATA_W'(4'b1111));
      write_csr(CSR_UNUSED, {4{16'h5A5A}});
      send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0));
      for (n = 0; n < 4; n++)
         send_req(rand_req());
      settle();
      write_csr(CSR_RATE,   '0);
      write_csr(CSR_BUCKET, '0);
      write_csr(CSR_CCCH,   '0);
      for (n = 0; n < 5; n++)
         send_req(rand_req());
      settle();
      // Largest finite rate into full buckets: credits reach the clamp quickly.
      write_csr(CSR_RATE,   {4{16'hFFFE}});
      write_csr(CSR_BUCKET, '1);
      for (n = 0; n < 8; n++)
         send_req(rand_req());
      settle();
   endtask

   // Several phases, each with fresh random tables and a mix of requests.
   task automatic test_random_traffic();
      int phase;
      int n;
      for (phase = 0; phase < 5; phase++) begin
         write_csr(CSR_RATE,   rand_rates());
         write_csr(CSR_BUCKET, rand_buckets());
         write_csr(CSR_CCCH,   CSR_DATA_W'($urandom_range(0, 15)));
         for (n = 0; n < 200; n++)
            send_req(rand_req());
         settle();
      end
   endtask

   // The receiver holds off while grants keep coming, so the result register
   // fills, a second grant waits behind it and the request channel stalls.
   task automatic test_backpressure();
      int n;
      hold_req = 1'b1;
      for (n = 0; n < 12; n++)
         send_req(make_req(REQ_GRANT, rand_bytes(), rand_bytes(), rand_bytes(),
                           rand_bytes(), rand_bytes()));
      for (n = 0; n < 20; n++)
         send_req(rand_req());
      settle();
   endtask

   // Full-rate transfers with neither side idling.
   task automatic test_full_rate();
      int n;
      idle_on  = 1'b0;
      stall_on = 1'b0;
      write_csr(CSR_RATE,   rand_rates());
      write_csr(CSR_BUCKET, rand_buckets());
      write_csr(CSR_CCCH,   CSR_DATA_W'($urandom_range(0, 15)));
      for (n = 0; n < 250; n++)
         send_req(rand_req());
      settle();
   endtask

   initial begin : run_tests
      int i;
      clock     = 1'b0;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid           = 1'b0;
      req_if.req_type        = REQ_TICK;
      req_if.grant_space     = '0;
      req_if.pending_bytes_0 = '0;
      req_if.pending_bytes_1 = '0;
      req_if.pending_bytes_2 = '0;
      req_if.pending_bytes_3 = '0;
      rate_tbl   = '0;
      bucket_tbl = '0;
      ccch_slots = '0;
      for (i = 0; i < SLOTS; i++)
         credit[i] = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_extremes();
      test_random_traffic();
      test_backpressure();
      test_full_rate();

      if (failures == 0 && split_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
